>>> design/lrurl_pkg.sv
// ----------------------------------------------------------------------------
// lrurl_pkg
// Shared field widths, operation codes and controller/datapath bundles for
// the recency list core.
// ----------------------------------------------------------------------------
package lrurl_pkg;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 10;
    localparam int CNT_W    = 11;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOUCH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd1024;

    typedef struct packed {
        logic load_item;
        logic rd_links;
        logic unlink_wr;
        logic link_a;
        logic link_b;
        logic sel_victim;
        logic load_result;
    } lrurl_cmd_t;

    typedef struct packed {
        logic              op_ok;
        logic [MODE_W-1:0] mode;
        logic              evicting;
        logic              evict_due;
        logic              head_valid;
        logic              out_free;
    } lrurl_stat_t;

endpackage

>>> design/lrurl_ram.sv
// ----------------------------------------------------------------------------
// lrurl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lrurl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/lrurl_dpath.sv
// ----------------------------------------------------------------------------
// lrurl_dpath
// Datapath: item registers, head/tail links, link memories, limit register
// and the result register.
// ----------------------------------------------------------------------------
module lrurl_dpath #(
    parameter int POOL_ENTRIES = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lrurl_pkg::lrurl_cmd_t               cmd,
    output lrurl_pkg::lrurl_stat_t              stat,
    input  logic [lrurl_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                                cfg_valid,
    input  logic [lrurl_pkg::CNT_W-1:0]         cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrurl_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int CW = (LW > lrurl_pkg::ID_W) ? LW : lrurl_pkg::ID_W;
    localparam logic [LW-1:0] NO_LINK = LW'(POOL_ENTRIES);

    logic [lrurl_pkg::MODE_W-1:0] s_mode;
    logic [lrurl_pkg::ID_W-1:0]   s_id;
    logic [lrurl_pkg::CNT_W-1:0]  s_count;
    logic [CW-1:0]                s_id_w;

    logic [lrurl_pkg::MODE_W-1:0] mode_reg;
    logic [lrurl_pkg::CNT_W-1:0]  count_reg;
    logic                         in_pool_reg;
    logic [IW-1:0]                cur_reg;
    logic                         evicting_reg;
    logic [LW-1:0]                head_reg;
    logic [LW-1:0]                head_next;
    logic [LW-1:0]                tail_reg;
    logic [LW-1:0]                tail_next;
    logic [lrurl_pkg::CNT_W-1:0]  max_reg;
    logic                         valid_reg;
    logic                         status_reg;
    logic [lrurl_pkg::ID_W-1:0]   evicted_reg;

    logic          prev_we;
    logic [IW-1:0] prev_waddr;
    logic [LW-1:0] prev_wdata;
    logic [LW-1:0] prev_rdata;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [LW-1:0] next_wdata;
    logic [LW-1:0] next_rdata;

    logic [LW-1:0] p_lnk;
    logic [LW-1:0] n_lnk;
    logic [LW-1:0] cur_lnk;
    logic          head_valid;
    logic          tail_valid;
    logic          out_free;

    // tdata: mode [1:0], slot_id [11:2], entry_count [22:12]
    assign s_mode  = s_tdata[1:0];
    assign s_id    = s_tdata[11:2];
    assign s_count = s_tdata[22:12];
    assign s_id_w  = CW'(s_id);

    assign cur_lnk    = LW'(cur_reg);
    assign head_valid = (head_reg != NO_LINK);
    assign tail_valid = (tail_reg != NO_LINK);
    assign p_lnk      = (prev_rdata < NO_LINK) ? prev_rdata : NO_LINK;
    assign n_lnk      = (next_rdata < NO_LINK) ? next_rdata : NO_LINK;
    assign out_free   = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mode_reg    <= s_mode;
            count_reg   <= s_count;
            in_pool_reg <= (s_id_w < CW'(POOL_ENTRIES));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evicting_reg <= 1'b0;
        end else if (cmd.load_item) begin
            evicting_reg <= 1'b0;
        end else if (cmd.sel_victim) begin
            evicting_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cur_reg <= IW'(s_id);
        end else if (cmd.sel_victim) begin
            cur_reg <= IW'(tail_reg);
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        prev_we    = 1'b0;
        prev_waddr = cur_reg;
        prev_wdata = NO_LINK;
        next_we    = 1'b0;
        next_waddr = cur_reg;
        next_wdata = NO_LINK;
        if (cmd.unlink_wr) begin
            if (head_reg == cur_lnk) begin
                head_next = n_lnk;
            end
            if (tail_reg == cur_lnk) begin
                tail_next = p_lnk;
            end
            prev_we    = (n_lnk != NO_LINK);
            prev_waddr = IW'(n_lnk);
            prev_wdata = p_lnk;
            next_we    = (p_lnk != NO_LINK);
            next_waddr = IW'(p_lnk);
            next_wdata = n_lnk;
        end else if (cmd.link_a) begin
            head_next = cur_lnk;
            prev_we   = 1'b1;
            next_we   = 1'b1;
            if (head_valid) begin
                prev_waddr = IW'(head_reg);
                prev_wdata = cur_lnk;
                next_wdata = head_reg;
            end else begin
                tail_next = cur_lnk;
            end
        end else if (cmd.link_b) begin
            prev_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= NO_LINK;
            tail_reg <= NO_LINK;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= lrurl_pkg::MAX_ENTRIES_RST;
        end else if (cfg_valid) begin
            max_reg <= cfg_data;
        end
    end

    lrurl_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_ENTRIES)
    ) u_prev_ram (
        .clk   (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (cmd.rd_links),
        .raddr (cur_reg),
        .rdata (prev_rdata)
    );

    lrurl_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_ENTRIES)
    ) u_next_ram (
        .clk   (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (cmd.rd_links),
        .raddr (cur_reg),
        .rdata (next_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            status_reg  <= evicting_reg;
            evicted_reg <= evicting_reg ? lrurl_pkg::ID_W'(cur_reg) : '0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(lrurl_pkg::M_DATA_W - lrurl_pkg::ID_W - 1){1'b0}},
                       evicted_reg, status_reg};

    assign stat.op_ok      = in_pool_reg && (mode_reg != lrurl_pkg::MODE_NONE);
    assign stat.mode       = mode_reg;
    assign stat.evicting   = evicting_reg;
    assign stat.evict_due  = (count_reg > max_reg) && tail_valid;
    assign stat.head_valid = head_valid;
    assign stat.out_free   = out_free;

endmodule

>>> design/lrurl_ctrl.sv
// ----------------------------------------------------------------------------
// lrurl_ctrl
// Controller: sequences link reads, unlink, head link and eviction steps.
// ----------------------------------------------------------------------------
module lrurl_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lrurl_pkg::lrurl_stat_t stat,
    output lrurl_pkg::lrurl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_UNL  = 3'd2;
    localparam logic [2:0] ST_LNA  = 3'd3;
    localparam logic [2:0] ST_LNB  = 3'd4;
    localparam logic [2:0] ST_CHK  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd_links = 1'b1;
                if (stat.evicting) begin
                    state_next = ST_UNL;
                end else if (!stat.op_ok) begin
                    state_next = ST_DONE;
                end else if (stat.mode == lrurl_pkg::MODE_ADD) begin
                    state_next = ST_LNA;
                end else begin
                    state_next = ST_UNL;
                end
            end
            ST_UNL: begin
                cmd.unlink_wr = 1'b1;
                if (stat.evicting || stat.mode == lrurl_pkg::MODE_REMOVE) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LNA;
                end
            end
            ST_LNA: begin
                cmd.link_a = 1'b1;
                state_next = stat.head_valid ? ST_LNB : ST_CHK;
            end
            ST_LNB: begin
                cmd.link_b = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (stat.evict_due) begin
                    cmd.sel_victim = 1'b1;
                    state_next     = ST_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/lru_recency_list_core.sv
// ----------------------------------------------------------------------------
// lru_recency_list_core
// Recency order over a pool of entry slots as a doubly linked list.
//
// s_ channel takes one operation item (add, remove, touch) per handshake.
// m_ channel returns exactly one result item per operation: status and the
// evicted slot when an add or touch pushes the count above max_entries.
// cfg_ channel writes max_entries; write it only while the block is idle.
// One item is in work at a time; the next item is accepted only after the
// result of the last one is loaded. The controller runs the dependent steps
// on the two link memories in order: read links, unlink, link at head, evict.
// A skipped operation only reads links, a remove ends after the unlink, an
// add skips the unlink, and an eviction reads and unlinks the tail slot.
// The result sits in an output register, so the next item is accepted while
// the receiver stalls; that item then waits before its result is loaded.
// Reset empties the list and sets max_entries to 1024; link memories are
// not cleared and need no sweep.
// ----------------------------------------------------------------------------
module lru_recency_list_core #(
    parameter int POOL_ENTRIES = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: mode [1:0], slot_id [11:2], entry_count [22:12]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lrurl_pkg::S_DATA_W-1:0]     s_tdata,
    // tdata: status [0], evicted_id [10:1]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrurl_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lrurl_pkg::CNT_W-1:0]        cfg_data
);

    lrurl_pkg::lrurl_cmd_t  cmd;
    lrurl_pkg::lrurl_stat_t stat;

    assign cfg_ready = 1'b1;

    lrurl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrurl_dpath #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_no_id_without_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[10:1] == '0)
        else $error("evicted_id set without eviction");

    a_one_item_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result loaded in accept cycle");

    a_evict_only_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !cmd.load_result)
        else $error("result loaded right after accept");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recency list core. A generator walks the list
// through directed and random phases, predicts every status and evicted slot
// as it queues each item, and a monitor compares the returned items in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int POOL        = 1024;
    localparam int HALF_PERIOD = 6;
    localparam int RST_CYCLES  = 11;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int WF_PHASES   = 8;
    localparam int WF_ITEMS    = 95;
    localparam int BRK_ITEMS   = 60;
    localparam int END_CYCLES  = 20;
    localparam logic [lrurl_pkg::ID_W:0] NO_LINK = (lrurl_pkg::ID_W + 1)'(POOL);

    typedef struct packed {
        logic [lrurl_pkg::CNT_W-1:0]  cnt;
        logic [lrurl_pkg::ID_W-1:0]   id;
        logic [lrurl_pkg::MODE_W-1:0] mode;
    } lru_op_t;

    typedef struct packed {
        logic [lrurl_pkg::ID_W-1:0] evicted;
        logic                       status;
    } lru_verdict_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [lrurl_pkg::S_DATA_W-1:0] s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [lrurl_pkg::M_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lrurl_pkg::CNT_W-1:0]    cfg_data  = '0;

    // recency list as the generator sees it
    logic [lrurl_pkg::ID_W:0]    lru_prev [POOL];
    logic [lrurl_pkg::ID_W:0]    lru_next [POOL];
    logic [lrurl_pkg::ID_W:0]    lru_head;
    logic [lrurl_pkg::ID_W:0]    lru_tail;
    logic [lrurl_pkg::CNT_W-1:0] lru_max;
    bit                          slot_written [POOL];
    bit                          is_live [POOL];
    int                          live_ids [$];

    lru_op_t      op_queue [$];
    lru_verdict_t op_verdicts [$];
    lru_verdict_t verdicts_due [$];

    bit tx_idle  = 1'b0;
    bit rx_idle  = 1'b0;
    bit hold_req = 1'b0;
    int tx_wait  = 0;
    int rx_wait  = 0;
    int rx_hold_left = 0;
    int quiet    = 0;
    int errors   = 0;

    lru_recency_list_core #(
        .POOL_ENTRIES(POOL)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic void lru_unlink(input logic [lrurl_pkg::ID_W-1:0] id);
        logic [lrurl_pkg::ID_W:0] p;
        logic [lrurl_pkg::ID_W:0] n;
        p = lru_prev[id];
        n = lru_next[id];
        if (p >= POOL) p = NO_LINK;
        if (n >= POOL) n = NO_LINK;
        if (lru_head == {1'b0, id}) lru_head = n;
        if (lru_tail == {1'b0, id}) lru_tail = p;
        if (n != NO_LINK) lru_prev[n[lrurl_pkg::ID_W-1:0]] = p;
        if (p != NO_LINK) lru_next[p[lrurl_pkg::ID_W-1:0]] = n;
    endfunction

    function automatic lru_verdict_t lru_apply(input lru_op_t op);
        lru_verdict_t v;
        logic [lrurl_pkg::ID_W-1:0] victim;
        v = '0;
        if (op.mode == lrurl_pkg::MODE_NONE) return v;
        if (op.mode != lrurl_pkg::MODE_ADD) lru_unlink(op.id);
        if (op.mode == lrurl_pkg::MODE_REMOVE) return v;
        if (lru_head < POOL) begin
            lru_prev[lru_head[lrurl_pkg::ID_W-1:0]] = {1'b0, op.id};
            lru_next[op.id] = lru_head;
        end else begin
            lru_next[op.id] = NO_LINK;
            lru_tail = {1'b0, op.id};
        end
        lru_prev[op.id] = NO_LINK;
        lru_head = {1'b0, op.id};
        if (op.cnt > lru_max && lru_tail < POOL) begin
            victim = lru_tail[lrurl_pkg::ID_W-1:0];
            lru_unlink(victim);
            v.status  = 1'b1;
            v.evicted = victim;
        end
        return v;
    endfunction

    function automatic void live_drop(input int id);
        if (!is_live[id]) return;
        is_live[id] = 1'b0;
        for (int i = 0; i < live_ids.size(); i++) begin
            if (live_ids[i] == id) begin
                live_ids.delete(i);
                break;
            end
        end
    endfunction

    task automatic issue(input logic [lrurl_pkg::MODE_W-1:0] mode, input int id,
                         input int cnt);
        lru_op_t      op;
        lru_verdict_t v;
        op.mode = mode;
        op.id   = lrurl_pkg::ID_W'(id);
        op.cnt  = lrurl_pkg::CNT_W'(cnt);
        v = lru_apply(op);
        op_queue.push_back(op);
        op_verdicts.push_back(v);
        if (mode == lrurl_pkg::MODE_ADD || mode == lrurl_pkg::MODE_TOUCH) begin
            if (mode == lrurl_pkg::MODE_ADD) slot_written[id] = 1'b1;
            if (!is_live[id]) begin
                is_live[id] = 1'b1;
                live_ids.push_back(id);
            end
        end else if (mode == lrurl_pkg::MODE_REMOVE) begin
            live_drop(id);
        end
        if (v.status) live_drop(int'(v.evicted));
    endtask

    task automatic random_op(input bit broken);
        int r;
        int id;
        int cnt;
        bit noisy;
        r     = int'($urandom_range(0, 99));
        cnt   = int'($urandom_range(0, POOL));
        noisy = ($urandom_range(0, 9) == 0);
        if (r < 4) begin
            issue(lrurl_pkg::MODE_NONE, int'($urandom_range(0, POOL - 1)), cnt);
        end else if (broken && r < 20) begin
            // double add, or remove / touch of a slot that may be off the list
            do id = int'($urandom_range(0, POOL - 1)); while (!slot_written[id]);
            if (r % 3 == 0) issue(lrurl_pkg::MODE_ADD, id, cnt);
            else if (r % 3 == 1) issue(lrurl_pkg::MODE_REMOVE, id, cnt);
            else issue(lrurl_pkg::MODE_TOUCH, id, cnt);
        end else if (live_ids.size() == 0 || r < 55) begin
            do id = int'($urandom_range(0, POOL - 1)); while (is_live[id]);
            if (!noisy) cnt = live_ids.size() + 1;
            issue(lrurl_pkg::MODE_ADD, id, cnt);
        end else if (r < 80) begin
            id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            if (!noisy) cnt = live_ids.size();
            issue(lrurl_pkg::MODE_TOUCH, id, cnt);
        end else begin
            id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            if (!noisy) cnt = live_ids.size() - 1;
            issue(lrurl_pkg::MODE_REMOVE, id, cnt);
        end
    endtask

    task automatic wait_idle();
        while (op_queue.size() != 0 || op_verdicts.size() != 0 ||
               verdicts_due.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    task automatic write_max(input int val);
        wait_idle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= lrurl_pkg::CNT_W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        lru_max = lrurl_pkg::CNT_W'(val);
    endtask

    always @(posedge aclk) begin : op_driver
        if (s_tvalid && s_tready) verdicts_due.push_back(op_verdicts.pop_front());
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_wait > 0) begin
                s_tvalid <= 1'b0;
                tx_wait  <= tx_wait - 1;
            end else if (op_queue.size() != 0) begin
                s_tdata  <= lrurl_pkg::S_DATA_W'(op_queue.pop_front());
                s_tvalid <= 1'b1;
                tx_wait  <= tx_idle ? int'($urandom_range(0, 10)) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : verdict_monitor
        lru_verdict_t got;
        lru_verdict_t want;
        int w;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(lru_verdict_t)-1:0];
            if (verdicts_due.size() == 0) begin
                $display("%0t unexpected item: status %0d evicted %0d",
                         $time, got.status, got.evicted);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (got.status != want.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.evicted != want.evicted) begin
                    $display("%0t evicted_id: expected %0d actual %0d",
                             $time, want.evicted, got.evicted);
                    errors++;
                end
            end
        end
        if (!aresetn || rx_hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            w = rx_idle ? int'($urandom_range(0, 10)) : 0;
            rx_wait  <= w;
            m_tready <= (w == 0);
        end else if (!m_tready) begin
            if (rx_wait > 0) rx_wait <= rx_wait - 1;
            else m_tready <= 1'b1;
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_left <= 0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (hold_req) begin
            rx_hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int wf_max [WF_PHASES];
        int lim;
        wf_max = '{1024, 16, 0, 3, 200, 64, -1, 16};
        lru_head = NO_LINK;
        lru_tail = NO_LINK;
        lru_max  = lrurl_pkg::MAX_ENTRIES_RST;
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit: no eviction even at full count
        issue(lrurl_pkg::MODE_ADD, 0, 1);
        issue(lrurl_pkg::MODE_ADD, 1023, 2);
        issue(lrurl_pkg::MODE_ADD, 512, 1024);
        issue(lrurl_pkg::MODE_TOUCH, 0, 3);
        issue(lrurl_pkg::MODE_TOUCH, 0, 3);
        issue(lrurl_pkg::MODE_TOUCH, 1023, 3);
        issue(lrurl_pkg::MODE_REMOVE, 512, 2);
        issue(lrurl_pkg::MODE_REMOVE, 1023, 1);
        issue(lrurl_pkg::MODE_NONE, 1023, 1024);
        issue(lrurl_pkg::MODE_REMOVE, 0, 0);
        issue(lrurl_pkg::MODE_NONE, 0, 0);

        // limit zero: new entry evicted on an empty list
        write_max(0);
        issue(lrurl_pkg::MODE_ADD, 100, 1);
        issue(lrurl_pkg::MODE_ADD, 1, 0);
        issue(lrurl_pkg::MODE_ADD, 2, 2);
        issue(lrurl_pkg::MODE_TOUCH, 2, 1);
        issue(lrurl_pkg::MODE_ADD, 3, 0);
        issue(lrurl_pkg::MODE_REMOVE, 3, 1024);

        for (int ph = 0; ph < WF_PHASES; ph++) begin
            lim = (wf_max[ph] < 0) ? int'($urandom_range(0, POOL)) : wf_max[ph];
            write_max(lim);
            tx_idle <= ph[0];
            rx_idle <= ph[1];
            for (int i = 0; i < WF_ITEMS; i++) begin
                random_op(1'b0);
                if (ph == 5 && i == WF_ITEMS / 2) wait_idle();
            end
            if (ph == 2) begin
                @(posedge aclk);
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
        end

        // empty the list, then the broken cases
        while (live_ids.size() != 0)
            issue(lrurl_pkg::MODE_REMOVE, live_ids[0], live_ids.size() - 1);
        write_max(0);
        issue(lrurl_pkg::MODE_ADD, 0, 0);
        issue(lrurl_pkg::MODE_ADD, 1023, 0);
        issue(lrurl_pkg::MODE_ADD, 0, 0);
        issue(lrurl_pkg::MODE_REMOVE, 0, 0);
        issue(lrurl_pkg::MODE_ADD, 5, 1);
        issue(lrurl_pkg::MODE_REMOVE, 512, 1024);
        issue(lrurl_pkg::MODE_TOUCH, 100, 1024);

        for (int ph = 0; ph < 2; ph++) begin
            write_max(ph == 0 ? int'($urandom_range(0, POOL)) : 5);
            tx_idle <= 1'b1;
            rx_idle <= 1'b1;
            for (int i = 0; i < BRK_ITEMS; i++) random_op(1'b1);
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge aclk);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
